// File: sv/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the aging priority scheduler
// Slot table entry layout, table write command and the input and result
// beats that cross the top-level channels.
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

	localparam int SLOTS   = 8;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REM_W   = 16;
	localparam int BPRIO_W = 7;
	localparam int PRIO_W  = 8;
	localparam int CNT_W   = 32;

	// Most urgent priority that aging can reach.
	localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = -8'sd128;

	// Input function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [2:0]               slot;
		logic [REM_W-1:0]         run_time;
		logic [BPRIO_W-1:0]       base_priority;
	} in_t;

	typedef struct packed {
		logic                     granted;
		logic [2:0]               granted_slot;
		logic [REM_W-1:0]         remaining_left;
		logic signed [PRIO_W-1:0] priority_used;
		logic                     finished;
		logic                     first_run;
		logic                     switched;
		logic [CNT_W-1:0]         switch_count;
		logic [CNT_W-1:0]         time_now;
		logic                     all_idle;
	} out_t;

	typedef struct packed {
		logic [REM_W-1:0]         rem;
		logic [BPRIO_W-1:0]       iprio;
		logic signed [PRIO_W-1:0] cprio;
		logic                     has_run;
	} entry_t;

	typedef struct packed {
		logic                     we;
		logic [SLOT_W-1:0]        idx;
		entry_t                   data;
	} wr_t;

endpackage

`default_nettype wire

// File: sv/aging_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// aging_priority_scheduler_top: aging priority task scheduler
// Slot table, scan and update sequencer, and the result output register.
// ----------------------------------------------------------------------------
// The block keeps a table of task slots and takes one input beat at a time.
// A load beat fills one slot, and its result beat follows the write.
// A tick beat walks the table twice through its single read port: one pass
// over all slots finds the runnable slot with the smallest current priority
// (lowest index on a tie) using one comparator, and a second pass over all
// slots grants that slot one time unit and ages every other runnable slot.
// No new input beat is taken until the current beat's result has entered the
// output register. Each beat produces exactly one result beat; that beat sits
// in an output register, so the sequencer only waits on the output side when
// the previous result has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_scheduler_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire aps_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output aps_pkg::out_t      out_data
);
	import aps_pkg::*;

	wr_t               wr;
	logic [SLOT_W-1:0] rd_idx;
	entry_t            rd_entry;
	logic              idle;
	logic              push;
	logic              out_free;
	out_t              res;
	logic              out_valid_q;
	out_t              out_data_q;

	// The result register can take a new beat when it is empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	aps_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.idle     (idle)
	);

	aps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_free (out_free),
		.push     (push),
		.res      (res),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.idle     (idle)
	);

	// Output register: valid is control state, the payload is loaded on push.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: sv/aps_table.sv
// ----------------------------------------------------------------------------
// aps_table: task slot table
// One entry per slot, one write port and one read port addressed by the
// sequencer, plus an idle flag that is low while any slot has time left.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_table (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire aps_pkg::wr_t               wr,
	input  wire logic [aps_pkg::SLOT_W-1:0] rd_idx,
	output aps_pkg::entry_t                 rd_entry,
	output logic                            idle
);
	import aps_pkg::*;

	entry_t entry_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr.we) begin
			entry_q[wr.idx] <= wr.data;
		end
	end

	assign rd_entry = entry_q[rd_idx];

	always_comb begin
		idle = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			if (entry_q[i].rem != '0) begin
				idle = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/aps_ctrl.sv
// ----------------------------------------------------------------------------
// aps_ctrl: scheduler sequencer
// Writes one slot for a load beat. For a tick, walks the slot table once to
// find the most urgent runnable slot with a single comparator, then walks it
// again to grant and age. Every beat builds a result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire aps_pkg::in_t               in_data,
	input  wire logic                       out_free,
	output logic                            push,
	output aps_pkg::out_t                   res,
	output aps_pkg::wr_t                    wr,
	output logic [aps_pkg::SLOT_W-1:0]      rd_idx,
	input  wire aps_pkg::entry_t            rd_entry,
	input  wire logic                       idle
);
	import aps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	logic [2:0]               state_q;
	logic [SLOT_W-1:0]        idx_q;
	in_t                      item_q;
	logic                     best_v_q;
	logic [SLOT_W-1:0]        best_idx_q;
	logic signed [PRIO_W-1:0] best_prio_q;
	logic [SLOT_W-1:0]        last_slot_q;
	logic                     last_valid_q;
	logic [CNT_W-1:0]         tick_q;
	logic [CNT_W-1:0]         sw_q;
	logic [REM_W-1:0]         g_rem_q;
	logic                     g_fin_q;
	logic                     g_first_q;
	logic                     g_sw_q;

	logic                     better;
	logic                     is_best;
	logic [REM_W-1:0]         dec_rem;
	logic                     sw_now;

	// Compare unit for the scan: a runnable candidate beats the best seen so far.
	assign better  = (rd_entry.rem != '0) && (!best_v_q || (rd_entry.cprio < best_prio_q));
	assign is_best = (idx_q == best_idx_q);
	assign dec_rem = rd_entry.rem - REM_W'(1);
	assign sw_now  = last_valid_q && (last_slot_q != best_idx_q);

	assign in_ready = (state_q == ST_IDLE);
	assign rd_idx   = idx_q;
	assign push     = (state_q == ST_RESP) && out_free;

	always_comb begin
		wr = '0;
		unique case (state_q)
			ST_LOAD: begin
				wr.we           = (32'(item_q.slot) < SLOTS);
				wr.idx          = SLOT_W'(item_q.slot);
				wr.data.rem     = item_q.run_time;
				wr.data.iprio   = item_q.base_priority;
				wr.data.cprio   = {1'b0, item_q.base_priority};
				wr.data.has_run = 1'b0;
			end
			ST_UPD: begin
				wr.we   = best_v_q && (rd_entry.rem != '0);
				wr.idx  = idx_q;
				wr.data = rd_entry;
				if (is_best) begin
					wr.data.rem     = dec_rem;
					wr.data.has_run = 1'b1;
					if (dec_rem != '0) begin
						wr.data.cprio = {1'b0, rd_entry.iprio};
					end
				end else if (rd_entry.cprio != PRIO_FLOOR) begin
					wr.data.cprio = rd_entry.cprio - 8'sd1;
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	always_comb begin
		res                = '0;
		res.granted        = best_v_q;
		res.granted_slot   = 3'(best_idx_q);
		res.remaining_left = g_rem_q;
		res.priority_used  = best_prio_q;
		res.finished       = g_fin_q;
		res.first_run      = g_first_q;
		res.switched       = g_sw_q;
		res.switch_count   = sw_q;
		res.time_now       = tick_q;
		res.all_idle       = idle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			item_q       <= '0;
			best_v_q     <= 1'b0;
			best_idx_q   <= '0;
			best_prio_q  <= '0;
			last_slot_q  <= '0;
			last_valid_q <= 1'b0;
			tick_q       <= '0;
			sw_q         <= '0;
			g_rem_q      <= '0;
			g_fin_q      <= 1'b0;
			g_first_q    <= 1'b0;
			g_sw_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q      <= in_data;
						idx_q       <= '0;
						best_v_q    <= 1'b0;
						best_idx_q  <= '0;
						best_prio_q <= '0;
						g_rem_q     <= '0;
						g_fin_q     <= 1'b0;
						g_first_q   <= 1'b0;
						g_sw_q      <= 1'b0;
						state_q     <= (in_data.func == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
					end
				end
				ST_LOAD: begin
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if (better) begin
						best_v_q    <= 1'b1;
						best_idx_q  <= idx_q;
						best_prio_q <= rd_entry.cprio;
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_UPD;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_UPD: begin
					if (best_v_q && is_best) begin
						g_rem_q      <= dec_rem;
						g_fin_q      <= (dec_rem == '0);
						g_first_q    <= !rd_entry.has_run;
						g_sw_q       <= sw_now;
						sw_q         <= sw_q + CNT_W'(sw_now);
						last_slot_q  <= best_idx_q;
						last_valid_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_RESP;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_RESP: begin
					if (out_free) begin
						if (item_q.func == FUNC_TICK) begin
							tick_q <= tick_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sw_step: assert property (@(posedge clk) disable iff (!arst_n)
		(sw_q == $past(sw_q)) || (sw_q == $past(sw_q) + 32'd1))
		else $error("switch count moved by more than one");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr.we)
		else $error("slot table written during the priority scan");

	a_tick_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> $past(push && (item_q.func == FUNC_TICK)))
		else $error("tick count advanced without a tick result");
`endif

endmodule

`default_nettype wire
